FILE: hdl/grid_frontier_check_assert.svh
// Assertion macros for the grid frontier check RTL.
`ifndef GRID_FRONTIER_CHECK_ASSERT_SVH
`define GRID_FRONTIER_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset.
`define GFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Plain condition that holds at every rising clock edge outside reset.
`define GFC_ASSERT_ALWAYS(name, expr, msg) \
  `GFC_ASSERT(name, 1'b1 |-> (expr), msg)
`else
`define GFC_ASSERT(name, prop, msg)
`define GFC_ASSERT_ALWAYS(name, expr, msg)
`endif

`endif

FILE: hdl/gfc_pkg.sv
// Types, constants and helpers for the grid frontier check.
package gfc_pkg;

  // Field and port widths
  localparam int unsigned CELL_W       = 8;
  localparam int unsigned POS_W        = 22;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

  // Defaults
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned RESET_WIDTH    = 1024;
  localparam int unsigned RESET_HEIGHT   = 1;

  // Cell codes
  localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;
  localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;

  typedef enum logic [1:0] {
    CLS_FREE     = 2'd0,
    CLS_UNKNOWN  = 2'd1,
    CLS_OCCUPIED = 2'd2
  } cls_e;

  // Map a raw cell byte to its class
  function automatic cls_e classify(input logic [CELL_W-1:0] v);
    cls_e c;
    if (v == CELL_FREE) begin
      c = CLS_FREE;
    end else if (v == CELL_UNKNOWN) begin
      c = CLS_UNKNOWN;
    end else begin
      c = CLS_OCCUPIED;
    end
    return c;
  endfunction

endpackage

FILE: hdl/grid_frontier_check.sv
// Grid frontier check: streaming frontier search over an occupancy grid.
`include "grid_frontier_check_assert.svh"

// Cells arrive in raster order, one signed byte per word (0 free, -1 unknown, else
// occupied). A free cell with an unknown 4-neighbor inside the grid is a frontier.
// After the last cell of a map_width x map_height grid one result word gives
// map_closed and the lowest frontier raster index (0 when closed); the scan then
// restarts. Throughput is one cell per clock while the input is not stalled: the line
// store of the previous row is read when a cell is accepted and written back from the
// judge stage, with a bypass for single-column maps where the same entry is read and
// written in the same cycle. The result word is registered when the last cell leaves
// the judge stage. An unclaimed result stalls the input only once the next map's
// last cell waits in the judge stage behind it. The line store needs no clearing
// pass after reset, since the first row ignores what it reads from it.
// Writing either register restarts the scan; write only while the block is idle.
module grid_frontier_check
  import gfc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // cell stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] cell_value
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata    // [0] map_closed, [22:1] first_frontier_index
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // Clamped register values
  function automatic logic [CW-1:0] width_last(input logic [WIDTH_REG_W-1:0] v);
    int unsigned e;
    e = 32'(v);
    if (e == 0) e = 1;
    if (e > MAX_WIDTH) e = MAX_WIDTH;
    return CW'(e - 1);
  endfunction

  function automatic logic [RW-1:0] height_last(input logic [HEIGHT_REG_W-1:0] v);
    int unsigned e;
    e = 32'(v);
    if (e == 0) e = 1;
    if (e > MAX_HEIGHT) e = MAX_HEIGHT;
    return RW'(e - 1);
  endfunction

  // Configuration
  logic [CW-1:0]    w_last_q;
  logic [POS_W-1:0] w_eff_q;
  logic [RW-1:0]    h_last_q;
  logic             restart;

  assign restart = cfg_we_i &&
                   ((cfg_idx_i == REG_MAP_WIDTH) || (cfg_idx_i == REG_MAP_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= width_last(WIDTH_REG_W'(RESET_WIDTH));
      w_eff_q  <= POS_W'(width_last(WIDTH_REG_W'(RESET_WIDTH))) + POS_W'(1);
      h_last_q <= height_last(HEIGHT_REG_W'(RESET_HEIGHT));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_WIDTH: begin
          w_last_q <= width_last(cfg_data_i[WIDTH_REG_W-1:0]);
          w_eff_q  <= POS_W'(width_last(cfg_data_i[WIDTH_REG_W-1:0])) + POS_W'(1);
        end
        REG_MAP_HEIGHT: begin
          h_last_q <= height_last(cfg_data_i[HEIGHT_REG_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the pipe moves unless a map's last cell waits behind an unclaimed result
  logic m_valid_q;
  logic adv;
  logic accept;

  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Scan position
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [POS_W-1:0] idx_q;
  cls_e             left_q;
  cls_e             cls_in;
  logic             last_col;
  logic             last_row;

  assign cls_in   = classify(s_axis_tdata[CELL_W-1:0]);
  assign last_col = (col_q == w_last_q);
  assign last_row = (row_q == h_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      idx_q  <= '0;
      left_q <= CLS_OCCUPIED;
    end else if (restart) begin
      col_q  <= '0;
      row_q  <= '0;
      idx_q  <= '0;
      left_q <= CLS_OCCUPIED;
    end else if (accept) begin
      if (last_col) begin
        col_q  <= '0;
        left_q <= CLS_OCCUPIED;
        if (last_row) begin
          row_q <= '0;
          idx_q <= '0;
        end else begin
          row_q <= row_q + RW'(1);
          idx_q <= idx_q + POS_W'(1);
        end
      end else begin
        col_q  <= col_q + CW'(1);
        idx_q  <= idx_q + POS_W'(1);
        left_q <= cls_in;
      end
    end
  end

  // Judge stage registers
  logic             s1_valid_q;
  cls_e             s1_cls_q;
  cls_e             s1_left_q;
  logic             s1_has_left_q;
  logic             s1_has_up_q;
  logic [POS_W-1:0] s1_idx_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_last_q;
  logic             s1_fwd_q;
  cls_e             s1_fwd_cls_q;
  logic             s1_fire;

  // only a last cell needs the result register free
  assign adv     = !(s1_valid_q && s1_last_q) || !m_valid_q || m_axis_tready;
  assign s1_fire = s1_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cls_q      <= cls_in;
      s1_left_q     <= left_q;
      s1_has_left_q <= (col_q != '0);
      s1_has_up_q   <= (row_q != '0);
      s1_idx_q      <= idx_q;
      s1_col_q      <= col_q;
      s1_last_q     <= last_col && last_row;
      // same entry written by the judge stage this cycle
      s1_fwd_q      <= s1_valid_q && (s1_col_q == col_q);
      s1_fwd_cls_q  <= s1_cls_q;
    end
  end

  // Line store: read at accept, written back from the judge stage
  cls_e row_classes_q [MAX_WIDTH];
  cls_e rd_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      row_classes_q[s1_col_q] <= s1_cls_q;
    end
    if (accept) begin
      rd_q <= row_classes_q[col_q];
    end
  end

  // Pair judgment against left and upper neighbors
  cls_e             up_cls;
  logic             a_hit;
  logic [POS_W-1:0] a_pos;
  logic             b_hit;
  logic [POS_W-1:0] b_pos;
  logic             seen_q;
  logic [POS_W-1:0] pos_q;
  logic             seen_mid;
  logic [POS_W-1:0] pos_mid;
  logic             seen_d;
  logic [POS_W-1:0] pos_d;

  assign up_cls = s1_fwd_q ? s1_fwd_cls_q : rd_q;

  always_comb begin
    a_hit = 1'b0;
    a_pos = s1_idx_q;
    if (s1_has_left_q) begin
      if (s1_left_q == CLS_FREE && s1_cls_q == CLS_UNKNOWN) begin
        a_hit = 1'b1;
        a_pos = s1_idx_q - POS_W'(1);
      end else if (s1_cls_q == CLS_FREE && s1_left_q == CLS_UNKNOWN) begin
        a_hit = 1'b1;
      end
    end
    b_hit = 1'b0;
    b_pos = s1_idx_q;
    if (s1_has_up_q) begin
      if (up_cls == CLS_FREE && s1_cls_q == CLS_UNKNOWN) begin
        b_hit = 1'b1;
        b_pos = s1_idx_q - w_eff_q;
      end else if (s1_cls_q == CLS_FREE && up_cls == CLS_UNKNOWN) begin
        b_hit = 1'b1;
      end
    end
  end

  // Keep the lowest frontier index
  always_comb begin
    seen_mid = seen_q;
    pos_mid  = pos_q;
    if (a_hit && (!seen_q || a_pos < pos_q)) begin
      pos_mid = a_pos;
    end
    if (a_hit) seen_mid = 1'b1;
    seen_d = seen_mid;
    pos_d  = pos_mid;
    if (b_hit && (!seen_mid || b_pos < pos_mid)) begin
      pos_d = b_pos;
    end
    if (b_hit) seen_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      pos_q  <= '0;
    end else if (restart) begin
      seen_q <= 1'b0;
      pos_q  <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        seen_q <= 1'b0;
        pos_q  <= '0;
      end else begin
        seen_q <= seen_d;
        pos_q  <= pos_d;
      end
    end
  end

  // Result register
  logic [OUT_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      m_data_q <= {1'b0, (seen_d ? pos_d : POS_W'(0)), !seen_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks
  `GFC_ASSERT(a_result_from_last, $rose(m_axis_tvalid) |-> $past(s1_valid_q && s1_last_q), "result without last cell")
  `GFC_ASSERT(a_fwd_single_col, (s1_valid_q && s1_fwd_q) |-> (w_last_q == '0), "bypass on wide map")
  `GFC_ASSERT_ALWAYS(a_pos_in_grid, (col_q <= w_last_q) && (row_q <= h_last_q), "scan out of grid")
  `GFC_ASSERT(a_pos_clear, !seen_q |-> (pos_q == '0), "stale frontier index")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the grid frontier check: directed and random maps.
`timescale 1ns / 100ps

module testbench;
  import gfc_pkg::*;

  localparam int unsigned MAX_W        = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H        = DEF_MAX_HEIGHT;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 120;

  // One result word, laid out as on m_axis_tdata
  typedef struct packed {
    logic [POS_W-1:0] index;
    logic             closed;
  } map_result_t;

  typedef enum logic [1:0] {
    STIM_WIDTH,
    STIM_HEIGHT,
    STIM_CELL
  } stim_kind_e;

  typedef struct {
    stim_kind_e            kind;
    logic [CFG_DATA_W-1:0] value;
    bit                    typed;
    map_result_t           want;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] cell_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [0] map_closed, [22:1] first_frontier_index

  // Scoreboard and traffic control
  map_result_t pending_maps[$];
  int unsigned mismatch_count = 0;
  int unsigned random_items   = 0;
  bit          src_idles      = 1'b1;
  bit          sink_idles     = 1'b1;
  bit          hold_off_req   = 1'b0;

  // Frontier predictor state
  cls_e                    line_cls[MAX_W];
  cls_e                    prev_cls;
  int unsigned             scan_col;
  int unsigned             scan_row;
  bit                      front_seen;
  logic [POS_W-1:0]        front_pos;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  grid_frontier_check DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Scan position back to the top-left corner
  function automatic void restart_scan();
    prev_cls   = CLS_OCCUPIED;
    scan_col   = 0;
    scan_row   = 0;
    front_seen = 1'b0;
    front_pos  = '0;
  endfunction

  // Zero and oversize register values are clamped
  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_H) return MAX_H;
    return 32'(height_reg);
  endfunction

  // Keep the lowest frontier index seen in this map
  function automatic void note_frontier(input longint unsigned pos);
    logic [POS_W-1:0] p;
    p = pos[POS_W-1:0];
    if (!front_seen || p < front_pos) front_pos = p;
    front_seen = 1'b1;
  endfunction

  // A free cell next to an unknown one is a frontier, in either order
  function automatic void judge_pair(input cls_e earlier, input cls_e later,
                                     input longint unsigned earlier_pos,
                                     input longint unsigned later_pos);
    if (earlier == CLS_FREE && later == CLS_UNKNOWN) note_frontier(earlier_pos);
    if (later == CLS_FREE && earlier == CLS_UNKNOWN) note_frontier(later_pos);
  endfunction

  // Advance the scan by one cell; returns 1 with the map result on the last cell
  function automatic bit predict_cell(input logic [CELL_W-1:0] v, output map_result_t res);
    int unsigned     w;
    int unsigned     h;
    cls_e            c;
    longint unsigned idx;
    w   = used_width();
    h   = used_height();
    res = '0;
    if (v == CELL_FREE) begin
      c = CLS_FREE;
    end else if (v == CELL_UNKNOWN) begin
      c = CLS_UNKNOWN;
    end else begin
      c = CLS_OCCUPIED;
    end
    idx = 64'(scan_row);
    idx = idx * w + scan_col;
    // left neighbor, then the one above; nothing outside the grid
    if (scan_col > 0) judge_pair(prev_cls, c, idx - 1, idx);
    if (scan_row > 0 && scan_col < MAX_W) judge_pair(line_cls[scan_col], c, idx - w, idx);
    if (scan_col < MAX_W) line_cls[scan_col] = c;
    prev_cls = c;
    if (scan_col + 1 >= w) begin
      prev_cls = CLS_OCCUPIED;
      scan_col = 0;
      if (scan_row + 1 >= h) begin
        res.closed = !front_seen;
        res.index  = front_seen ? front_pos : '0;
        restart_scan();
        return 1'b1;
      end
      scan_row++;
    end else begin
      scan_col++;
    end
    return 1'b0;
  endfunction

  // Mostly free and unknown cells so frontiers are common
  function automatic logic [CELL_W-1:0] rand_cell();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CELL_FREE;
      4, 5, 6:    return CELL_UNKNOWN;
      default:    return CELL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic stim_row_t stim(input stim_kind_e kind, input logic [CFG_DATA_W-1:0] value,
                                     input bit typed, input bit closed,
                                     input int unsigned index);
    stim_row_t r;
    r.kind         = kind;
    r.value        = value;
    r.typed        = typed;
    r.want.closed  = closed;
    r.want.index   = POS_W'(index);
    return r;
  endfunction

  // Stop offering cells and let the block drain completely
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only with the block idle; restarts the scan
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAP_WIDTH) begin
      width_reg = data[WIDTH_REG_W-1:0];
    end else begin
      height_reg = data[HEIGHT_REG_W-1:0];
    end
    restart_scan();
  endtask

  // Offer one cell word, wait for the handshake, then log its expected result
  task automatic send_cell(input logic [CELL_W-1:0] v, input bit typed, input map_result_t want);
    map_result_t res;
    bit          done;
    if (src_idles && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    done = predict_cell(v, res);
    if (typed) begin
      pending_maps.push_back(want);
    end else if (done) begin
      pending_maps.push_back(res);
    end
  endtask

  // Configure a grid and stream whole maps, optionally with a cut-off tail
  task automatic run_maps(input logic [CFG_DATA_W-1:0] w_data,
                          input logic [CFG_DATA_W-1:0] h_data,
                          input int unsigned n_maps, input bit cut_short, input bit hold);
    int unsigned cells;
    int unsigned map_size;
    int unsigned pause_at;
    if ($urandom_range(0, 1) != 0) begin
      write_reg(REG_MAP_WIDTH, w_data);
      write_reg(REG_MAP_HEIGHT, h_data);
    end else begin
      write_reg(REG_MAP_HEIGHT, h_data);
      write_reg(REG_MAP_WIDTH, w_data);
    end
    hold_off_req = hold;
    map_size = used_width() * used_height();
    cells    = map_size * n_maps;
    if (cut_short) cells += $urandom_range(0, map_size - 1);
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cells) : cells + 1;
    for (int unsigned i = 0; i < cells; i++) begin
      // sender waits for the scoreboard to empty mid-map
      if (i == pause_at) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_maps.size() != 0);
      end
      send_cell(rand_cell(), 1'b0, '0);
      random_items++;
    end
  endtask

  // Result sink: random back-pressure plus one long hold-off
  initial begin : result_sink
    int unsigned stall;
    map_result_t got;
    map_result_t want;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[POS_W:0];
        if (pending_maps.size() == 0) begin
          $display("%0t: unexpected result word: closed %0d index %0d",
                   $time, got.closed, got.index);
          mismatch_count++;
        end else begin
          want = pending_maps.pop_front();
          if (got.closed !== want.closed) begin
            $display("%0t: map_closed expected %0d actual %0d", $time, want.closed, got.closed);
            mismatch_count++;
          end
          if (got.index !== want.index) begin
            $display("%0t: first_frontier_index expected %0d actual %0d",
                     $time, want.index, got.index);
            mismatch_count++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_CYCLES;
      end else if (stall == 0 && sink_idles && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main stimulus
  initial begin : stimulus
    stim_row_t             rows[$];
    map_result_t           none;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    none       = '0;
    width_reg  = WIDTH_REG_W'(RESET_WIDTH);
    height_reg = HEIGHT_REG_W'(RESET_HEIGHT);
    foreach (line_cls[i]) line_cls[i] = CLS_FREE;
    restart_scan();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: one full-width row
    for (int unsigned i = 0; i < RESET_WIDTH; i++) send_cell(rand_cell(), 1'b0, none);

    // single-cell maps are always closed, whatever the byte
    rows.push_back(stim(STIM_WIDTH,  13'd1, 0, 0, 0));
    rows.push_back(stim(STIM_HEIGHT, 13'd1, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 1, 1, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 1, 1, 0));
    rows.push_back(stim(STIM_CELL,   13'h7F, 1, 1, 0));
    rows.push_back(stim(STIM_CELL,   13'h80, 1, 1, 0));
    // zero registers act as one
    rows.push_back(stim(STIM_WIDTH,  13'd0, 0, 0, 0));
    rows.push_back(stim(STIM_HEIGHT, 13'd0, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 1, 1, 0));
    // horizontal pair, both orders
    rows.push_back(stim(STIM_WIDTH,  13'd2, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 1, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 1, 0, 1));
    // vertical pair, both orders
    rows.push_back(stim(STIM_WIDTH,  13'd1, 0, 0, 0));
    rows.push_back(stim(STIM_HEIGHT, 13'd2, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 1, 0, 1));
    rows.push_back(stim(STIM_CELL,   13'h00, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 1, 0, 0));
    // unknown at a row end and free at the next row start do not touch
    rows.push_back(stim(STIM_WIDTH,  13'd2, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 1, 1, 0));
    // 3x3 with a free center above an unknown
    rows.push_back(stim(STIM_WIDTH,  13'd3, 0, 0, 0));
    rows.push_back(stim(STIM_HEIGHT, 13'd3, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h00, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'hFF, 0, 0, 0));
    rows.push_back(stim(STIM_CELL,   13'h05, 0, 0, 0));
    foreach (rows[k]) begin
      case (rows[k].kind)
        STIM_WIDTH:  write_reg(REG_MAP_WIDTH, rows[k].value);
        STIM_HEIGHT: write_reg(REG_MAP_HEIGHT, rows[k].value);
        default:     send_cell(rows[k].value[CELL_W-1:0], rows[k].typed, rows[k].want);
      endcase
    end

    // one result per cell while the sink holds off: block fills and stalls
    src_idles = 1'b0;
    run_maps(13'd1, 13'd1, 40, 1'b0, 1'b1);
    src_idles = 1'b1;

    // random small grids
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      src_idles  = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       w_data = '0;
        1:       w_data = CFG_DATA_W'($urandom_range(13, 40));
        default: w_data = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      // upper data bits are outside the width register
      w_data[CFG_DATA_W-1:WIDTH_REG_W] = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       h_data = '0;
        1:       h_data = CFG_DATA_W'($urandom_range(11, 24));
        default: h_data = CFG_DATA_W'($urandom_range(1, 10));
      endcase
      run_maps(w_data, h_data, $urandom_range(1, 2), $urandom_range(0, 5) == 0, 1'b0);
    end

    // closing stretch at full rate on both sides
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    run_maps(CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 8)), 3,
             1'b0, 1'b0);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
